### rtl/hms_pkg.sv
// Shared types, operation codes and constants of the hour/second/millisecond time unit.
package hms_pkg;

	// Stream widths; the data widths are padded to whole bytes
	localparam int S_TDATA_W = 208;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 160;

	// Radix constants
	localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
	localparam logic [31:0] MS_PER_SEC   = 32'd1000;
	localparam logic [31:0] MS_PER_HOUR  = 32'd3600000;

	// Operation codes
	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_SUB     = 3'd1,
		OP_ADD_MS  = 3'd2,
		OP_SUB_MS  = 3'd3,
		OP_CMP     = 3'd4,
		OP_CONV    = 3'd5,
		OP_SET_UTC = 3'd6
	} op_t;

	// One input item as captured
	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_hour;
		logic [11:0]        a_sec;
		logic [9:0]         a_msec;
		logic signed [31:0] b_hour;
		logic [11:0]        b_sec;
		logic [9:0]         b_msec;
		logic signed [31:0] ms_amount;
		logic [31:0]        utc_value;
		logic [31:0]        max_delta;
	} in_t;

	// Operands formed for normalisation, plus compare and convert results
	typedef struct packed {
		logic [2:0]         op;
		logic               is_arith;
		logic signed [31:0] h;
		logic signed [13:0] s;
		logic signed [31:0] m;
		logic               is_less;
		logic               is_equal;
		logic [31:0]        tsec;
		logic [31:0]        tms;
		logic [31:0]        utc_value;
		logic [31:0]        max_delta;
	} prep_t;

endpackage

### rtl/hms_time_arithmetic_unit.sv
// Throughput: one item per clock while results are taken; six register stages each hold one item
// and advance independently, so a stalled result does not block input while a stage is free.
// The offset is updated in stage three, so later items see it in order.
// Reset (arst_n low) empties every stage and clears the UTC offset to zero.
module hms_time_arithmetic_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// a_hour, a_sec, a_msec, b_hour, b_sec, b_msec, ms_amount, utc_value, max_delta, pad
	input  logic [hms_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// op
	input  logic [hms_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// r_hour, r_sec, r_msec, is_less, is_equal, total_sec, total_msec, utc_sec, accepted, pad
	output logic [hms_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import hms_pkg::*;

	// Results that ride alongside the normalisation pipeline
	typedef struct packed {
		logic        is_arith;
		logic        is_less;
		logic        is_equal;
		logic [31:0] tsec;
		logic [31:0] tms;
		logic [31:0] utc_sec;
		logic        accepted;
	} side_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	in_t   in_d, in_s1;
	prep_t prep_d, prep_s2;
	side_t side_d, side_s3, side_s4, side_s5, side_s6;

	logic [31:0]        utc_sec;
	logic               utc_ok;
	logic signed [31:0] r_hour;
	logic [11:0]        r_sec;
	logic [9:0]         r_msec;

	// Stage advance: a stage moves when empty or when the next one moves
	assign en_s6 = !v_s6 || m_axis_tready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Unpack the incoming item
	assign in_d.op        = s_axis_tuser;
	assign in_d.a_hour    = s_axis_tdata[31:0];
	assign in_d.a_sec     = s_axis_tdata[43:32];
	assign in_d.a_msec    = s_axis_tdata[53:44];
	assign in_d.b_hour    = s_axis_tdata[85:54];
	assign in_d.b_sec     = s_axis_tdata[97:86];
	assign in_d.b_msec    = s_axis_tdata[107:98];
	assign in_d.ms_amount = s_axis_tdata[139:108];
	assign in_d.utc_value = s_axis_tdata[171:140];
	assign in_d.max_delta = s_axis_tdata[203:172];

	always_ff @(posedge clk) begin
		if (en_s1) in_s1 <= in_d;
	end

	// Stage 2: operands, compare and totals
	hms_prep u_prep (
		.in_d   (in_s1),
		.prep_d (prep_d)
	);

	always_ff @(posedge clk) begin
		if (en_s2) prep_s2 <= prep_d;
	end

	// Stage 3: offset handling
	hms_utc u_utc (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (en_s3 && v_s2),
		.op        (prep_s2.op),
		.tsec      (prep_s2.tsec),
		.utc_value (prep_s2.utc_value),
		.max_delta (prep_s2.max_delta),
		.utc_sec   (utc_sec),
		.accepted  (utc_ok)
	);

	// Fields an operation does not produce are zero
	always_comb begin
		side_d.is_arith = prep_s2.is_arith;
		side_d.is_less  = prep_s2.is_less;
		side_d.is_equal = prep_s2.is_equal;
		side_d.tsec     = (prep_s2.op == OP_CONV) ? prep_s2.tsec : '0;
		side_d.tms      = (prep_s2.op == OP_CONV) ? prep_s2.tms : '0;
		side_d.utc_sec  = (prep_s2.op == OP_CONV) ? utc_sec : '0;
		side_d.accepted = (prep_s2.op == OP_SET_UTC) ? utc_ok : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en_s3) side_s3 <= side_d;
		if (en_s4) side_s4 <= side_s3;
		if (en_s5) side_s5 <= side_s4;
		if (en_s6) side_s6 <= side_s5;
	end

	// Stages 3 to 6: normalisation
	hms_norm u_norm (
		.clk    (clk),
		.adv    ({en_s6, en_s5, en_s4, en_s3}),
		.h_in   (prep_s2.h),
		.s_in   (prep_s2.s),
		.m_in   (prep_s2.m),
		.r_hour (r_hour),
		.r_sec  (r_sec),
		.r_msec (r_msec)
	);

	// Pack the result item
	assign m_axis_tdata[31:0]    = side_s6.is_arith ? r_hour : '0;
	assign m_axis_tdata[43:32]   = side_s6.is_arith ? r_sec : '0;
	assign m_axis_tdata[53:44]   = side_s6.is_arith ? r_msec : '0;
	assign m_axis_tdata[54]      = side_s6.is_less;
	assign m_axis_tdata[55]      = side_s6.is_equal;
	assign m_axis_tdata[87:56]   = side_s6.tsec;
	assign m_axis_tdata[119:88]  = side_s6.tms;
	assign m_axis_tdata[151:120] = side_s6.utc_sec;
	assign m_axis_tdata[152]     = side_s6.accepted;
	assign m_axis_tdata[159:153] = '0;

endmodule

### rtl/hms_prep.sv
// Operand formation, compare and time conversion for one item.
module hms_prep (
	input  hms_pkg::in_t   in_d,
	output hms_pkg::prep_t prep_d
);
	import hms_pkg::*;

	logic [31:0] a_hour_u;

	assign a_hour_u = in_d.a_hour;

	// Raw sums and differences ahead of normalisation
	always_comb begin
		prep_d.op        = in_d.op;
		prep_d.is_arith  = (in_d.op inside {OP_ADD, OP_SUB, OP_ADD_MS, OP_SUB_MS});
		prep_d.h         = in_d.a_hour;
		prep_d.s         = {2'b00, in_d.a_sec};
		prep_d.m         = {22'd0, in_d.a_msec};
		case (in_d.op)
			OP_ADD: begin
				prep_d.h = in_d.a_hour + in_d.b_hour;
				prep_d.s = {2'b00, in_d.a_sec} + {2'b00, in_d.b_sec};
				prep_d.m = {22'd0, in_d.a_msec} + {22'd0, in_d.b_msec};
			end
			OP_SUB: begin
				prep_d.h = in_d.a_hour - in_d.b_hour;
				prep_d.s = {2'b00, in_d.a_sec} - {2'b00, in_d.b_sec};
				prep_d.m = {22'd0, in_d.a_msec} - {22'd0, in_d.b_msec};
			end
			OP_ADD_MS: begin
				prep_d.m = {22'd0, in_d.a_msec} + in_d.ms_amount;
			end
			OP_SUB_MS: begin
				prep_d.m = {22'd0, in_d.a_msec} - in_d.ms_amount;
			end
			default: begin
				prep_d.m = '0;
			end
		endcase
	end

	// Lexicographic compare on raw fields
	always_comb begin
		prep_d.is_less  = 1'b0;
		prep_d.is_equal = 1'b0;
		if (in_d.op == OP_CMP) begin
			prep_d.is_less = ($signed(in_d.a_hour) < $signed(in_d.b_hour)) ||
				((in_d.a_hour == in_d.b_hour) && (in_d.a_sec < in_d.b_sec)) ||
				((in_d.a_hour == in_d.b_hour) && (in_d.a_sec == in_d.b_sec) &&
				 (in_d.a_msec < in_d.b_msec));
			prep_d.is_equal = (in_d.a_hour == in_d.b_hour) && (in_d.a_sec == in_d.b_sec) &&
				(in_d.a_msec == in_d.b_msec);
		end
	end

	// Totals, wrapping at 32 bits
	assign prep_d.tsec = a_hour_u * SEC_PER_HOUR + {20'd0, in_d.a_sec};
	assign prep_d.tms  = a_hour_u * MS_PER_HOUR + {20'd0, in_d.a_sec} * MS_PER_SEC +
		{22'd0, in_d.a_msec};

	assign prep_d.utc_value = in_d.utc_value;
	assign prep_d.max_delta = in_d.max_delta;

endmodule

### rtl/hms_utc.sv
// UTC offset register, offset update with change limit, and UTC seconds.
module hms_utc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [2:0]  op,
	input  logic [31:0] tsec,
	input  logic [31:0] utc_value,
	input  logic [31:0] max_delta,
	output logic [31:0] utc_sec,
	output logic        accepted
);
	import hms_pkg::*;

	logic [31:0] offset_q;
	logic [31:0] new_off;
	logic [31:0] diff;

	// Candidate offset and its distance from the stored one
	assign new_off = utc_value - tsec;
	assign diff    = (new_off >= offset_q) ? (new_off - offset_q) : (offset_q - new_off);

	// Limit applies only while the stored offset is nonzero and a limit is given
	assign accepted = !((offset_q != '0) && (max_delta != '0) && (diff > max_delta));
	assign utc_sec  = tsec + offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (load && (op == OP_SET_UTC) && accepted) begin
			offset_q <= new_off;
		end
	end

endmodule

### rtl/hms_norm.sv
// Normalisation pipeline: floor division by 1000 then by 3600, one multiply per stage.
module hms_norm (
	input  logic               clk,
	input  logic [3:0]         adv,
	input  logic signed [31:0] h_in,
	input  logic signed [13:0] s_in,
	input  logic signed [31:0] m_in,
	output logic signed [31:0] r_hour,
	output logic [11:0]        r_sec,
	output logic [9:0]         r_msec
);
	import hms_pkg::*;

	// Exact reciprocals: x/1000 = (x>>3)/125, x/3600 = (x>>4)/225
	localparam logic [28:0] MS_RECIP  = 29'd274877907;
	localparam logic [19:0] SEC_RECIP = 20'd596524;
	localparam logic [9:0]  MS_LAST   = 10'(MS_PER_SEC - 32'd1);
	localparam logic [11:0] SEC_LAST  = 12'(SEC_PER_HOUR - 32'd1);

	// Stage 3: fold sign of milliseconds, quotient by 1000
	logic        neg_m;
	logic [30:0] x_m;
	logic [56:0] prod_m;

	logic signed [31:0] h_s3;
	logic signed [13:0] s_s3;
	logic               neg_m_s3;
	logic [9:0]         xlo_m_s3;
	logic [21:0]        qu_m_s3;

	assign neg_m  = m_in[31];
	assign x_m    = neg_m ? ~m_in[30:0] : m_in[30:0];
	assign prod_m = 57'(x_m[30:3]) * 57'(MS_RECIP);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			h_s3     <= h_in;
			s_s3     <= s_in;
			neg_m_s3 <= neg_m;
			xlo_m_s3 <= x_m[9:0];
			qu_m_s3  <= prod_m[56:35];
		end
	end

	// Stage 4: millisecond remainder, carry into seconds
	logic [9:0]         r_m;
	logic [9:0]         msec_fix;
	logic [22:0]        q_m;
	logic signed [23:0] sp;

	logic signed [31:0] h_s4;
	logic signed [23:0] sp_s4;
	logic [9:0]         msec_s4;

	assign r_m      = xlo_m_s3 - 10'(qu_m_s3) * 10'(MS_PER_SEC);
	assign msec_fix = neg_m_s3 ? (MS_LAST - r_m) : r_m;
	assign q_m      = neg_m_s3 ? ~{1'b0, qu_m_s3} : {1'b0, qu_m_s3};
	assign sp       = {{10{s_s3[13]}}, s_s3} + {q_m[22], q_m};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			h_s4    <= h_s3;
			sp_s4   <= sp;
			msec_s4 <= msec_fix;
		end
	end

	// Stage 5: fold sign of seconds, quotient by 3600
	logic        neg_s;
	logic [22:0] x_s;
	logic [38:0] prod_s;

	logic signed [31:0] h_s5;
	logic [9:0]         msec_s5;
	logic               neg_s_s5;
	logic [11:0]        xlo_s_s5;
	logic [11:0]        qu_s_s5;

	assign neg_s  = sp_s4[23];
	assign x_s    = neg_s ? ~sp_s4[22:0] : sp_s4[22:0];
	assign prod_s = 39'(x_s[22:4]) * 39'(SEC_RECIP);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			h_s5     <= h_s4;
			msec_s5  <= msec_s4;
			neg_s_s5 <= neg_s;
			xlo_s_s5 <= x_s[11:0];
			qu_s_s5  <= prod_s[38:27];
		end
	end

	// Stage 6: seconds remainder, carry into hours
	logic [11:0] r_s;
	logic [11:0] sec_fix;
	logic [31:0] q_s;

	assign r_s     = xlo_s_s5 - qu_s_s5 * 12'(SEC_PER_HOUR);
	assign sec_fix = neg_s_s5 ? (SEC_LAST - r_s) : r_s;
	assign q_s     = neg_s_s5 ? ~{20'd0, qu_s_s5} : {20'd0, qu_s_s5};

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			r_hour <= h_s5 + q_s;
			r_sec  <= sec_fix;
			r_msec <= msec_s5;
		end
	end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the hour/second/millisecond time arithmetic unit.
`timescale 1ns / 100ps

module tb_top;
	import hms_pkg::*;

	localparam int          CLK_HALF   = 10;
	localparam int          RST_CYCLES = 12;
	localparam int          N_RANDOM   = 550;
	localparam int          HOLD_AFTER = 120;
	localparam int          HOLD_LEN   = 300;
	localparam int unsigned LIMIT      = 500000;
	localparam logic [2:0]  OP_UNDEF   = 3'd7;
	localparam longint      MS_L       = longint'(MS_PER_SEC);
	localparam longint      SEC_L      = longint'(SEC_PER_HOUR);

	// Slave tdata, from the lowest bit up: a_hour, a_sec, a_msec, b_hour, b_sec, b_msec,
	// ms_amount, utc_value, max_delta, pad
	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] max_delta;
		logic [31:0] utc_value;
		logic [31:0] ms_amount;
		logic [9:0]  b_msec;
		logic [11:0] b_sec;
		logic [31:0] b_hour;
		logic [9:0]  a_msec;
		logic [11:0] a_sec;
		logic [31:0] a_hour;
	} hms_in_t;

	typedef struct packed {
		logic [2:0] op;
		hms_in_t    d;
	} hms_item_t;

	// Master tdata, from the lowest bit up: r_hour, r_sec, r_msec, is_less, is_equal,
	// total_sec, total_msec, utc_sec, accepted, pad
	typedef struct packed {
		logic [6:0]  pad;
		logic        accepted;
		logic [31:0] utc_sec;
		logic [31:0] total_msec;
		logic [31:0] total_sec;
		logic        is_equal;
		logic        is_less;
		logic [9:0]  r_msec;
		logic [11:0] r_sec;
		logic [31:0] r_hour;
	} hms_res_t;

	// Directed row: operands, then whether the expected result is typed in, then that result
	typedef struct {
		logic [2:0]  op;
		logic [31:0] ah;
		logic [11:0] asec;
		logic [9:0]  ams;
		logic [31:0] bh;
		logic [11:0] bsec;
		logic [9:0]  bms;
		logic [31:0] ms;
		logic [31:0] utc;
		logic [31:0] maxd;
		bit          lit;
		logic [31:0] eh;
		logic [11:0] esec;
		logic [9:0]  ems;
		bit          elt;
		bit          eeq;
		logic [31:0] ets;
		logic [31:0] etms;
		logic [31:0] eutc;
		bit          eacc;
	} dir_row_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	hms_res_t    pending_results [$];
	logic [31:0] hms_model_offset = '0;
	int unsigned n_sent           = 0;
	int unsigned n_checked        = 0;
	int unsigned n_utc_stored     = 0;
	int unsigned n_utc_rejected   = 0;
	int unsigned errors           = 0;

	// Directed items: carries and borrows, wrap of hours, compare paths, offset limit cases
	dir_row_t dir_tab [25] = '{
		'{OP_CONV, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_CONV, 1, 1, 1, 0, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 3601, 3601001, 3601, 0},
		'{OP_ADD, 0, 3599, 999, 0, 0, 1, 0, 0, 0,
			1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SUB, 0, 0, 0, 0, 0, 1, 0, 0, 0,
			1, 32'hFFFFFFFF, 3599, 999, 0, 0, 0, 0, 0, 0},
		'{OP_ADD, 32'h7FFFFFFF, 0, 0, 1, 0, 0, 0, 0, 0,
			1, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_ADD_MS, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SUB_MS, 0, 0, 5, 0, 0, 0, 32'h80000000, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_ADD_MS, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 0,
			1, 32'hFFFFFFFF, 3599, 999, 0, 0, 0, 0, 0, 0},
		'{OP_CMP, 5, 6, 7, 5, 6, 7, 0, 0, 0,
			1, 0, 0, 0, 0, 1, 0, 0, 0, 0},
		'{OP_CMP, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 1, 0, 0, 0, 0, 0},
		'{OP_CMP, 3, 10, 5, 3, 10, 6, 0, 0, 0,
			1, 0, 0, 0, 1, 0, 0, 0, 0, 0},
		'{OP_CMP, 32'h7FFFFFFF, 0, 0, 32'h80000000, 3599, 999, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 1000, 1,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 1},
		'{OP_CONV, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 0, 0, 1000, 0},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 5000, 10,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 1010, 10,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 1},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF5, 10,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SET_UTC, 1, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF5, 3599,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_ADD, 0, 12'hFFF, 10'h3FF, 0, 12'hFFF, 10'h3FF, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_CONV, 32'h80000000, 12'hFFF, 10'h3FF, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_CMP, 0, 12'hFFF, 0, 0, 3599, 10'h3FF, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SUB, 32'h80000000, 0, 0, 32'h7FFFFFFF, 3599, 999, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_UNDEF, 32'hFFFFFFFF, 12'hFFF, 10'h3FF, 32'hFFFFFFFF, 12'hFFF, 10'h3FF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SET_UTC, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	hms_time_arithmetic_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// Two's complement wrap to 32 bits
	function automatic longint wrap32(input longint x);
		logic signed [31:0] t;
		t = x[31:0];
		return longint'(t);
	endfunction

	// Carry milliseconds into seconds and seconds into hours, borrowing on a negative remainder
	function automatic void carry_hms(inout longint h, inout longint s, inout longint m);
		longint q;
		q = m / MS_L;
		s = wrap32(s + q);
		m = m - q * MS_L;
		if (m < 0) begin
			m = m + MS_L;
			s = wrap32(s - 1);
		end
		q = s / SEC_L;
		h = wrap32(h + q);
		s = s - q * SEC_L;
		if (s < 0) begin
			s = s + SEC_L;
			h = wrap32(h - 1);
		end
	endfunction

	// Expected result of one item; updates the offset copy on set utc
	function automatic hms_res_t compute_hms(input hms_item_t it);
		hms_res_t    res;
		longint      h, s, m, ah, bh;
		logic [31:0] tsec, nw, diff;
		bit          ok;
		res  = '0;
		ah   = longint'($signed(it.d.a_hour));
		bh   = longint'($signed(it.d.b_hour));
		tsec = it.d.a_hour * SEC_PER_HOUR + 32'(it.d.a_sec);
		case (it.op)
			OP_ADD, OP_SUB, OP_ADD_MS, OP_SUB_MS: begin
				h = ah;
				s = longint'(it.d.a_sec);
				m = longint'(it.d.a_msec);
				case (it.op)
					OP_ADD: begin
						h = wrap32(ah + bh);
						s = s + longint'(it.d.b_sec);
						m = m + longint'(it.d.b_msec);
					end
					OP_SUB: begin
						h = wrap32(ah - bh);
						s = s - longint'(it.d.b_sec);
						m = m - longint'(it.d.b_msec);
					end
					OP_ADD_MS: m = wrap32(m + longint'($signed(it.d.ms_amount)));
					default:   m = wrap32(m - longint'($signed(it.d.ms_amount)));
				endcase
				carry_hms(h, s, m);
				res.r_hour = h[31:0];
				res.r_sec  = s[11:0];
				res.r_msec = m[9:0];
			end
			OP_CMP: begin
				res.is_equal = (it.d.a_hour == it.d.b_hour) && (it.d.a_sec == it.d.b_sec) &&
					(it.d.a_msec == it.d.b_msec);
				res.is_less = (ah < bh) ||
					(ah == bh && it.d.a_sec < it.d.b_sec) ||
					(ah == bh && it.d.a_sec == it.d.b_sec && it.d.a_msec < it.d.b_msec);
			end
			OP_CONV: begin
				res.total_sec  = tsec;
				res.total_msec = it.d.a_hour * MS_PER_HOUR + 32'(it.d.a_sec) * MS_PER_SEC +
					32'(it.d.a_msec);
				res.utc_sec    = tsec + hms_model_offset;
			end
			OP_SET_UTC: begin
				nw = it.d.utc_value - tsec;
				ok = 1'b1;
				// limit applies only while the stored offset is nonzero and a limit is given
				if (hms_model_offset != 0 && it.d.max_delta != 0) begin
					diff = (nw >= hms_model_offset) ? nw - hms_model_offset : hms_model_offset - nw;
					if (diff > it.d.max_delta)
						ok = 1'b0;
				end
				if (ok) begin
					hms_model_offset = nw;
					n_utc_stored++;
				end else begin
					n_utc_rejected++;
				end
				res.accepted = ok;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Gap length: mostly none or short, a few long, with calm stretches of no gaps
	function automatic int unsigned pick_gap(inout bit calm);
		int unsigned r;
		if ($urandom_range(0, 99) < 2)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// 32-bit signed value: small, full range, near the extremes or medium
	function automatic logic [31:0] rand_span32();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'(int'($urandom_range(0, 200)) - 100);
			4, 5, 6:    return $urandom;
			7:          return 32'h7FFFFFFF - $urandom_range(0, 3);
			8:          return 32'h80000000 + $urandom_range(0, 3);
			default:    return 32'(int'($urandom_range(0, 20000000)) - 10000000);
		endcase
	endfunction

	// Seconds and milliseconds mostly normalised, sometimes anywhere in the field
	function automatic logic [11:0] rand_sec();
		return ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 3599)) :
			12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [9:0] rand_msec();
		return ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 999)) :
			10'($urandom_range(0, 1023));
	endfunction

	// Random item; compare and set utc are steered towards their interesting paths
	function automatic hms_item_t rand_hms_item();
		hms_item_t   it;
		logic [31:0] tsec;
		int unsigned r;
		it = '0;
		r  = $urandom_range(0, 99);
		if (r < 14)      it.op = OP_ADD;
		else if (r < 28) it.op = OP_SUB;
		else if (r < 42) it.op = OP_ADD_MS;
		else if (r < 56) it.op = OP_SUB_MS;
		else if (r < 70) it.op = OP_CMP;
		else if (r < 84) it.op = OP_CONV;
		else if (r < 98) it.op = OP_SET_UTC;
		else             it.op = OP_UNDEF;
		it.d.a_hour    = rand_span32();
		it.d.a_sec     = rand_sec();
		it.d.a_msec    = rand_msec();
		it.d.b_hour    = rand_span32();
		it.d.b_sec     = rand_sec();
		it.d.b_msec    = rand_msec();
		it.d.ms_amount = rand_span32();
		it.d.utc_value = $urandom;
		it.d.max_delta = $urandom;
		case (it.op)
			OP_CMP: begin
				// equal operands, or ones that differ by one in a single field
				if ($urandom_range(0, 1)) begin
					it.d.b_hour = it.d.a_hour;
					it.d.b_sec  = it.d.a_sec;
					it.d.b_msec = it.d.a_msec;
					case ($urandom_range(0, 3))
						0: it.d.b_hour = it.d.a_hour + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFFFFFF);
						1: it.d.b_sec  = it.d.a_sec + ($urandom_range(0, 1) ? 12'd1 : 12'hFFF);
						2: it.d.b_msec = it.d.a_msec + ($urandom_range(0, 1) ? 10'd1 : 10'h3FF);
						default: ;
					endcase
				end
			end
			OP_SET_UTC: begin
				tsec = it.d.a_hour * SEC_PER_HOUR + 32'(it.d.a_sec);
				case ($urandom_range(0, 4))
					0, 1, 2: begin
						// new offset close to the present one, against a tight limit
						it.d.utc_value = tsec + hms_model_offset + 32'(int'($urandom_range(0, 60)) - 30);
						it.d.max_delta = $urandom_range(0, 40);
					end
					3:       it.d.max_delta = '0;
					default: ;
				endcase
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare one result item with the oldest expectation
	task automatic check_result(input hms_res_t got);
		hms_res_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result with nothing expected, expected none, actual %h", $time, got);
			errors++;
		end else begin
			want = pending_results.pop_front();
			check_field("r_hour",     want.r_hour,     got.r_hour);
			check_field("r_sec",      want.r_sec,      got.r_sec);
			check_field("r_msec",     want.r_msec,     got.r_msec);
			check_field("is_less",    want.is_less,    got.is_less);
			check_field("is_equal",   want.is_equal,   got.is_equal);
			check_field("total_sec",  want.total_sec,  got.total_sec);
			check_field("total_msec", want.total_msec, got.total_msec);
			check_field("utc_sec",    want.utc_sec,    got.utc_sec);
			check_field("accepted",   want.accepted,   got.accepted);
		end
		n_checked++;
	endtask

	// Offer one item, wait for it to be taken, then log what it must produce
	task automatic send_item(input hms_item_t it, input bit use_lit, input hms_res_t lit_res);
		hms_res_t want;
		s_axis_tdata  <= it.d;
		s_axis_tuser  <= it.op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		want = compute_hms(it);
		if (use_lit)
			want = lit_res;
		pending_results.push_back(want);
		n_sent++;
	endtask

	task automatic pause_tx(input int unsigned n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_tx();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Receiver: check each result item, random back-pressure and one long hold-off
	initial begin
		int unsigned gap_left;
		int unsigned n;
		bit          rx_calm;
		bit          hold_done;
		gap_left  = 0;
		rx_calm   = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result(hms_res_t'(m_axis_tdata));
			if (!hold_done && n_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				gap_left  = HOLD_LEN;
			end
			if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else begin
				n = pick_gap(rx_calm);
				if (n == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					gap_left = n - 1;
				end
			end
		end
	end

	// Watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Sender: reset, directed table, then random items with two drain pauses
	initial begin
		hms_item_t it;
		hms_res_t  lit_res;
		bit        tx_calm;
		tx_calm = 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			it             = '0;
			it.op          = dir_tab[i].op;
			it.d.a_hour    = dir_tab[i].ah;
			it.d.a_sec     = dir_tab[i].asec;
			it.d.a_msec    = dir_tab[i].ams;
			it.d.b_hour    = dir_tab[i].bh;
			it.d.b_sec     = dir_tab[i].bsec;
			it.d.b_msec    = dir_tab[i].bms;
			it.d.ms_amount = dir_tab[i].ms;
			it.d.utc_value = dir_tab[i].utc;
			it.d.max_delta = dir_tab[i].maxd;
			lit_res            = '0;
			lit_res.r_hour     = dir_tab[i].eh;
			lit_res.r_sec      = dir_tab[i].esec;
			lit_res.r_msec     = dir_tab[i].ems;
			lit_res.is_less    = dir_tab[i].elt;
			lit_res.is_equal   = dir_tab[i].eeq;
			lit_res.total_sec  = dir_tab[i].ets;
			lit_res.total_msec = dir_tab[i].etms;
			lit_res.utc_sec    = dir_tab[i].eutc;
			lit_res.accepted   = dir_tab[i].eacc;
			send_item(it, dir_tab[i].lit, lit_res);
			pause_tx(pick_gap(tx_calm));
		end
		drain_tx();

		lit_res = '0;
		for (int i = 0; i < N_RANDOM; i++) begin
			send_item(rand_hms_item(), 1'b0, lit_res);
			if (i == N_RANDOM / 2)
				drain_tx();
			else
				pause_tx(pick_gap(tx_calm));
		end
		drain_tx();
		repeat (12) @(posedge clk);

		$display("%0d items sent (%0d directed), %0d result items checked, %0d mismatches",
			n_sent, $size(dir_tab), n_checked, errors);
		$display("set utc: %0d offsets stored, %0d refused by the limit",
			n_utc_stored, n_utc_rejected);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/hms_pkg.sv
rtl/hms_prep.sv
rtl/hms_utc.sv
rtl/hms_norm.sv
rtl/hms_time_arithmetic_unit.sv
dv/tb_top.sv
